FILE: sv/two_sided_slot_allocator_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the slot allocator
// ---------------------------------------------------------------------------
`ifndef TWO_SIDED_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define TWO_SIDED_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TSA_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tsa check failed");
`define TSA_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tsa check failed");
`else
`define TSA_ASSERT_IMPL(label, clk, rst_n, a, c)
`define TSA_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: sv/tsa_pkg.sv
// ---------------------------------------------------------------------------
// tsa_pkg
// Shared types and constants of the two-sided slot allocator.
// ---------------------------------------------------------------------------
package tsa_pkg;
    localparam int FREE_DEPTH_DEF = 256;
    localparam int SLOT_BITS_DEF  = 16;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_BAD_WIDTH = 2'd2;
    localparam logic [1:0] ST_LIST_FULL = 2'd3;

    localparam logic [2:0] REG_LOW_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HIGH_WIDTH = 3'd1;
    localparam logic [2:0] REG_BOUND      = 3'd2;
    localparam logic [2:0] REG_START      = 3'd3;
    localparam logic [2:0] REG_STRIDE     = 3'd4;
    localparam logic [2:0] REG_CPU_BASE   = 3'd5;
    localparam logic [2:0] REG_GPU_BASE   = 3'd6;
    localparam logic [2:0] REG_GPU_VIS    = 3'd7;

    typedef struct packed {
        logic        op;
        logic [7:0]  block_width;
        logic [15:0] slot_offset;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_offset;
        logic [63:0] cpu_handle;
        logic [63:0] gpu_handle;
    } result_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture item, decode side
        logic scan;     // one compare/shift pass over the lists
        logic finish;   // compute handles, present result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
    } stat_t;
endpackage

FILE: sv/two_sided_slot_allocator_core.sv
// ---------------------------------------------------------------------------
// From start to result strobe: load, scan, finish, then the registered strobe.
// A new item is taken only while idle; the single scan pass over the free
// list cells decides each item. The receiver cannot stall: done is one pulse.
// Reset: counters and list fill counts clear; registers take their defaults.
// ---------------------------------------------------------------------------
// two_sided_slot_allocator_core
// Double-ended slot allocator with sorted free lists per side.
// ---------------------------------------------------------------------------
`include "two_sided_slot_allocator_core_defines.svh"
module two_sided_slot_allocator_core
#(
    parameter int FREE_DEPTH = tsa_pkg::FREE_DEPTH_DEF,
    parameter int SLOT_BITS  = tsa_pkg::SLOT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tsa_pkg::item_t   item,
    output logic             done,
    output tsa_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [63:0]      cfg_data
);
    logic [7:0]  low_width_reg, high_width_reg;
    logic [15:0] bound_reg, start_reg;
    logic [10:0] stride_reg;
    logic [63:0] cpu_base_reg, gpu_base_reg;
    logic        gpu_vis_reg;

    tsa_pkg::cmd_t  cmd;
    tsa_pkg::stat_t stat;

    assign cfg_ready = !busy;

    // configuration registers, written only while idle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_width_reg  <= 8'd1;
            high_width_reg <= 8'd2;
            bound_reg      <= 16'hFFFF;
            start_reg      <= 16'd0;
            stride_reg     <= 11'd32;
            cpu_base_reg   <= 64'd0;
            gpu_base_reg   <= 64'd0;
            gpu_vis_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tsa_pkg::REG_LOW_WIDTH:  low_width_reg  <= cfg_data[7:0];
                tsa_pkg::REG_HIGH_WIDTH: high_width_reg <= cfg_data[7:0];
                tsa_pkg::REG_BOUND:      bound_reg      <= cfg_data[15:0];
                tsa_pkg::REG_START:      start_reg      <= cfg_data[15:0];
                tsa_pkg::REG_STRIDE:     stride_reg     <= cfg_data[10:0];
                tsa_pkg::REG_CPU_BASE:   cpu_base_reg   <= cfg_data;
                tsa_pkg::REG_GPU_BASE:   gpu_base_reg   <= cfg_data;
                tsa_pkg::REG_GPU_VIS:    gpu_vis_reg    <= cfg_data[0];
                default:                 gpu_vis_reg    <= gpu_vis_reg;
            endcase
        end
    end

    tsa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    tsa_datapath
    #(
        .FREE_DEPTH (FREE_DEPTH),
        .SLOT_BITS  (SLOT_BITS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .item          (item),
        .low_width     (low_width_reg),
        .high_width    (high_width_reg),
        .bound         (bound_reg),
        .start_slot    (start_reg),
        .stride        (stride_reg),
        .cpu_base      (cpu_base_reg),
        .gpu_base      (gpu_base_reg),
        .gpu_vis       (gpu_vis_reg),
        .result_strobe (done),
        .result        (result)
    );

    // an accepted beat makes the block busy on the next cycle
    `TSA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // the strobe comes once the sequencer is back in idle
    `TSA_ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy)
    // failed results carry no offset
    `TSA_ASSERT_IMPL(a_fail_zero, clk, rst_n, done && result.status != tsa_pkg::ST_OK,
        result.granted_offset == 16'd0)
endmodule

FILE: sv/tsa_ctrl.sv
// ---------------------------------------------------------------------------
// tsa_ctrl
// Sequencer: load, scan until the datapath reports scan done, finish.
// ---------------------------------------------------------------------------
module tsa_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output tsa_pkg::cmd_t  cmd,
    input  tsa_pkg::stat_t stat
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

FILE: sv/tsa_datapath.sv
// ---------------------------------------------------------------------------
// tsa_datapath
// Counters, sorted free lists as compare-and-shift cells, handle arithmetic.
// ---------------------------------------------------------------------------
module tsa_datapath
#(
    parameter int FREE_DEPTH = tsa_pkg::FREE_DEPTH_DEF,
    parameter int SLOT_BITS  = tsa_pkg::SLOT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  tsa_pkg::cmd_t    cmd,
    output tsa_pkg::stat_t   stat,
    input  tsa_pkg::item_t   item,
    input  logic [7:0]       low_width,
    input  logic [7:0]       high_width,
    input  logic [15:0]      bound,
    input  logic [15:0]      start_slot,
    input  logic [10:0]      stride,
    input  logic [63:0]      cpu_base,
    input  logic [63:0]      gpu_base,
    input  logic             gpu_vis,
    output logic             result_strobe,
    output tsa_pkg::result_t result
);
    localparam int UW = $clog2(FREE_DEPTH + 1);
    localparam int IW = $clog2(FREE_DEPTH);

    // free list cells, one array per side
    logic [SLOT_BITS-1:0] list_reg [2][FREE_DEPTH];
    logic [UW-1:0]        used_reg [2];
    logic [SLOT_BITS-1:0] count_reg [2];

    logic                 op_reg, hi_reg, bad_reg;
    logic [7:0]           width_reg;
    logic [SLOT_BITS-1:0] off_reg;

    // decision made in the scan cycle
    logic [1:0]           st_reg;
    logic [SLOT_BITS-1:0] grant_reg;
    logic                 ok_reg;

    logic [SLOT_BITS-1:0] off_in;
    logic                 hi_in, bad_in;
    assign off_in = SLOT_BITS'(item.slot_offset);
    assign hi_in  = (item.block_width != low_width);
    assign bad_in = (item.block_width != low_width) && (item.block_width != high_width);

    // scan decision
    logic [UW-1:0]        my_used, ot_used;
    logic [SLOT_BITS-1:0] my_count, new_count, top_val, cull_lim;
    logic [SLOT_BITS+1:0] total;
    logic                 pop, bump, ins;
    logic [1:0]           st_c;

    assign my_used   = used_reg[hi_reg];
    assign ot_used   = used_reg[!hi_reg];
    assign my_count  = count_reg[hi_reg];
    assign top_val   = list_reg[hi_reg][IW'(my_used - UW'(1))];
    assign total     = (SLOT_BITS+2)'(count_reg[0]) + (SLOT_BITS+2)'(count_reg[1])
                     + (SLOT_BITS+2)'(width_reg);
    assign new_count = my_count + SLOT_BITS'(width_reg);
    assign cull_lim  = SLOT_BITS'(bound) - new_count;

    always_comb
    begin
        pop  = 1'b0;
        bump = 1'b0;
        ins  = 1'b0;
        st_c = tsa_pkg::ST_OK;
        if (bad_reg)
        begin
            st_c = tsa_pkg::ST_BAD_WIDTH;
        end
        else if (!op_reg)
        begin
            if (my_used != '0)
            begin
                pop = 1'b1;
            end
            else if (total > (SLOT_BITS+2)'(bound))
            begin
                st_c = tsa_pkg::ST_EXHAUSTED;
            end
            else
            begin
                bump = 1'b1;
            end
        end
        else if (my_used == UW'(FREE_DEPTH))
        begin
            st_c = tsa_pkg::ST_LIST_FULL;
        end
        else
        begin
            ins = 1'b1;
        end
    end

    // per-cell compare flags (independent)
    logic [FREE_DEPTH-1:0] gt_off, gt_lim, in_me, in_ot;
    logic [UW-1:0]         cull_cnt;

    always_comb
    begin
        for (int i = 0; i < FREE_DEPTH; i++)
        begin
            in_me[i]  = (UW'(i) < my_used);
            in_ot[i]  = (UW'(i) < ot_used);
            gt_off[i] = in_me[i] && (list_reg[hi_reg][i] > off_reg);
            gt_lim[i] = in_ot[i] && (list_reg[!hi_reg][i] > cull_lim);
        end
    end

    // lists ascending: first index above the limit is used minus the count above
    always_comb
    begin
        cull_cnt = '0;
        for (int i = 0; i < FREE_DEPTH; i++)
        begin
            if (in_ot[i] && !gt_lim[i])
            begin
                cull_cnt = UW'(i + 1);
            end
        end
    end

    assign stat.scan_done = 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= item.op;
            width_reg <= item.block_width;
            off_reg   <= off_in;
            hi_reg    <= hi_in;
            bad_reg   <= bad_in;
        end
        if (cmd.scan)
        begin
            st_reg    <= st_c;
            ok_reg    <= pop || bump;
            grant_reg <= pop ? top_val : (bump ? my_count : '0);
            if (ins)
            begin
                // cells above the new offset move up one place
                for (int i = 0; i < FREE_DEPTH; i++)
                begin
                    if (in_me[i] && gt_off[i] && (i + 1 < FREE_DEPTH))
                    begin
                        list_reg[hi_reg][(i + 1) % FREE_DEPTH] <= list_reg[hi_reg][i];
                    end
                end
                for (int i = 0; i < FREE_DEPTH; i++)
                begin
                    // insertion point: first cell greater, or the tail
                    if ((UW'(i) <= my_used)
                        && (gt_off[i] || UW'(i) == my_used)
                        && (i == 0 || !gt_off[(i + FREE_DEPTH - 1) % FREE_DEPTH]))
                    begin
                        list_reg[hi_reg][i] <= off_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg[0]  <= '0;
            used_reg[1]  <= '0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
        end
        else if (cmd.scan)
        begin
            if (pop)
            begin
                used_reg[hi_reg] <= my_used - UW'(1);
            end
            if (ins)
            begin
                used_reg[hi_reg] <= my_used + UW'(1);
            end
            if (bump)
            begin
                count_reg[hi_reg] <= new_count;
                used_reg[!hi_reg] <= cull_cnt;
            end
        end
    end

    // handles: small products, then base add and mirror in the finish cycle
    logic [63:0] lowbase, top, back, pos, cb, gb;
    logic [16:0] back_n;
    assign back_n = 17'(grant_reg) + 17'(width_reg);
    always_comb
    begin
        lowbase = 64'(start_slot) * 64'(stride);
        top     = 64'(bound) * 64'(stride);
        back    = 64'(back_n) * 64'(stride);
        pos     = 64'(grant_reg) * 64'(stride);
        cb      = cpu_base + lowbase;
        gb      = gpu_vis ? gpu_base + lowbase : 64'd0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result.status         <= st_reg;
            result.granted_offset <= ok_reg ? 16'(grant_reg) : 16'd0;
            result.cpu_handle     <= !ok_reg ? 64'd0
                                   : (hi_reg ? cb + top - back : cb + pos);
            result.gpu_handle     <= !ok_reg ? 64'd0
                                   : (hi_reg ? gb + top - back : gb + pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_strobe <= 1'b0;
        end
        else
        begin
            result_strobe <= cmd.finish;
        end
    end
endmodule
